FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/utf8gl_pkg.sv
// Types and constants of the UTF-8 glyph segment lookup unit.
package utf8gl_pkg;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned RANGE_W   = 2 * CP_W;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned SEG_IDX_W = 2;
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned APB_AW    = 6;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [1:0] {
    KIND_ASCII    = 2'd0,
    KIND_FOUND    = 2'd1,
    KIND_NOTFOUND = 2'd2,
    KIND_RAW      = 2'd3
  } kind_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_UTF8_MODE  = 3'd0,
    REG_SEGMENTED  = 3'd1,
    REG_SEG_COUNT  = 3'd2,
    REG_RANGE0     = 3'd3,
    REG_RANGE1     = 3'd4,
    REG_RANGE2     = 3'd5,
    REG_RANGE3     = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_e;

  // Continuation byte payload width.
  localparam int unsigned CONT_BITS = 6;

endpackage

FILE: rtl/utf8_glyph_segment_lookup_unit.sv
// UTF-8 glyph segment lookup unit: byte decoder, segment range match and config registers.
//
// Usage: text bytes enter on the input channel (in_valid_i, in_stall_o, text_byte_i).
// Each request is held in an input register; from there the UTF-8 decode, the
// segment range compares and the glyph offset subtraction run in one pass and fill the
// result register that drives the output channel (out_valid_o, out_stall_i and fields).
// A byte that completes a character gives one result; in UTF-8 mode lead bytes, incomplete
// sequences, stray continuation bytes and invalid bytes give none.
// A byte passes through the input register and then the result register before its
// result is on the output.
// Throughput: one byte per cycle while the receiver does not stall, set by the single
// decode-and-match pass between the input register and the result register.
// When the receiver stalls, the result register holds its item; the input register
// still advances bytes that give no result, and one byte waits in it otherwise before
// in_stall_o rises.
// Reset clears all configuration registers (no font, byte mode), the decoder
// accumulator and count, and both valid flags. Configuration goes through the APB port
// at byte address 8*i; the user must write it only while the unit is idle (not enforced).
`include "assert_macros.svh"

module utf8_glyph_segment_lookup_unit
  import utf8gl_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  // Byte input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           text_byte_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           result_kind_o,
  output logic [CP_W-1:0]      char_value_o,
  output logic [SEG_IDX_W-1:0] segment_index_o,
  output logic [CP_W-1:0]      glyph_offset_o
);

  // Configuration registers
  logic                  utf8_mode_q;
  logic                  segmented_q;
  logic [COUNT_W-1:0]    seg_count_q;
  logic [RANGE_W-1:0]    range_q [MAX_SEGMENTS];

  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[APB_AW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utf8_mode_q <= 1'b0;
      segmented_q <= 1'b0;
      seg_count_q <= '0;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        range_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_UTF8_MODE) utf8_mode_q <= pwdata[0];
      if (cfg_idx == REG_SEGMENTED) segmented_q <= pwdata[0];
      if (cfg_idx == REG_SEG_COUNT) seg_count_q <= pwdata[COUNT_W-1:0];
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        if (cfg_idx == REG_IDX_W'(REG_RANGE0 + i)) range_q[i] <= pwdata[RANGE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_UTF8_MODE: prdata = APB_DW'(utf8_mode_q);
      REG_SEGMENTED: prdata = APB_DW'(segmented_q);
      REG_SEG_COUNT: prdata = APB_DW'(seg_count_q);
      REG_RANGE0, REG_RANGE1, REG_RANGE2, REG_RANGE3: begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
          if (cfg_idx == REG_IDX_W'(REG_RANGE0 + i)) prdata = APB_DW'(range_q[i]);
        end
      end
      default: prdata = '0;
    endcase
  end

  // Input register and result register handshake
  logic            s1_valid_q;
  logic [7:0]      s1_byte_q;
  logic            s1_adv;
  logic            s1_load;
  logic            out_free;
  logic            res_valid;

  logic            out_valid_q;
  kind_e           out_kind_q;
  logic [CP_W-1:0] out_char_q;
  logic [SEG_IDX_W-1:0] out_seg_q;
  logic [CP_W-1:0] out_off_q;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_adv     = s1_valid_q & (~res_valid | out_free);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign s1_load    = in_valid_i & ~in_stall_o;

  // Decoder state
  logic [CP_W-1:0] acc_q, acc_d;
  logic [1:0]      cnt_q, cnt_d;

  // Decode and lookup for the byte in the input register
  logic            have_cp;
  logic [CP_W-1:0] cp;
  logic [CP_W-1:0] acc_shift;
  kind_e           res_kind;
  logic [CP_W-1:0] res_char;
  logic [SEG_IDX_W-1:0] res_seg;
  logic [CP_W-1:0] res_off;
  logic [CP_W-1:0] hit_first;
  logic            hit_any;
  logic [MAX_SEGMENTS-1:0] seg_hit;

  assign acc_shift = {acc_q[CP_W-CONT_BITS-1:0], s1_byte_q[CONT_BITS-1:0]};

  always_comb begin
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_hit[i] = (segmented_q ? (seg_count_q > COUNT_W'(i)) : (i == 0))
                   && (cp >= range_q[i][CP_W-1:0])
                   && (cp <= range_q[i][RANGE_W-1:CP_W]);
    end
  end

  always_comb begin
    hit_any   = 1'b0;
    hit_first = '0;
    res_seg   = '0;
    // Walk from the top so that the lowest matching segment wins.
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (seg_hit[i]) begin
        hit_any   = 1'b1;
        hit_first = range_q[i][CP_W-1:0];
        res_seg   = SEG_IDX_W'(i);
      end
    end
  end

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    have_cp   = 1'b0;
    cp        = CP_W'(s1_byte_q);
    res_valid = 1'b0;
    res_kind  = KIND_ASCII;
    res_char  = CP_W'(s1_byte_q);
    res_off   = '0;

    if (utf8_mode_q) begin
      priority if (!s1_byte_q[7]) begin
        res_valid = 1'b1;
      end else if (s1_byte_q[7:5] == 3'b110) begin
        acc_d = CP_W'(s1_byte_q[4:0]);
        cnt_d = 2'd1;
      end else if (s1_byte_q[7:4] == 4'b1110) begin
        acc_d = CP_W'(s1_byte_q[3:0]);
        cnt_d = 2'd2;
      end else if (s1_byte_q[7:3] == 5'b11110) begin
        acc_d = CP_W'(s1_byte_q[2:0]);
        cnt_d = 2'd3;
      end else if (s1_byte_q[7:6] == 2'b10 && cnt_q != 2'd0) begin
        cnt_d = cnt_q - 2'd1;
        if (cnt_q == 2'd1) begin
          have_cp = 1'b1;
          cp      = acc_shift;
          acc_d   = '0;
        end else begin
          acc_d = acc_shift;
        end
      end else begin
        // Stray continuation byte or a byte that can never start a sequence.
        acc_d = '0;
        cnt_d = 2'd0;
      end
    end else begin
      have_cp = 1'b1;
    end

    if (have_cp) begin
      res_valid = 1'b1;
      if (seg_count_q == '0) begin
        res_kind = KIND_RAW;
        res_char = CP_W'(cp[7:0]);
      end else begin
        acc_d    = '0;
        res_char = cp;
        if (hit_any) begin
          res_kind = KIND_FOUND;
          res_off  = cp - hit_first;
        end else begin
          res_kind = KIND_NOTFOUND;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= 2'd0;
    end else begin
      s1_valid_q  <= s1_load | (s1_valid_q & ~s1_adv);
      out_valid_q <= (s1_adv & res_valid) | (out_valid_q & out_stall_i);
      if (s1_adv) begin
        acc_q <= acc_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) s1_byte_q <= text_byte_i;
    if (s1_adv && res_valid) begin
      out_kind_q <= res_kind;
      out_char_q <= res_char;
      out_seg_q  <= (res_kind == KIND_FOUND) ? res_seg : '0;
      out_off_q  <= res_off;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign char_value_o    = out_char_q;
  assign segment_index_o = out_seg_q;
  assign glyph_offset_o  = out_off_q;

  // Assertions
  `ASSERT_PROP(a_found_offset, clk_i, rst_ni,
    (out_valid_q && out_kind_q == KIND_FOUND) |-> (out_off_q <= out_char_q),
    "glyph offset exceeds code point")
  `ASSERT_PROP(a_raw_fields, clk_i, rst_ni,
    (out_valid_q && out_kind_q == KIND_RAW) |->
      (out_char_q[CP_W-1:8] == '0 && out_seg_q == '0 && out_off_q == '0),
    "raw result carries more than a low byte")
  `ASSERT_PROP(a_ascii_range, clk_i, rst_ni,
    (out_valid_q && out_kind_q == KIND_ASCII) |-> (out_char_q[CP_W-1:7] == '0 && out_off_q == '0),
    "plain character above the ASCII range")
  `ASSERT_PROP(a_lookup_clears_acc, clk_i, rst_ni,
    (s1_adv && res_valid && (res_kind == KIND_FOUND || res_kind == KIND_NOTFOUND))
      |=> (acc_q == '0),
    "accumulator not cleared after a font lookup")

endmodule

FILE: tb/utf8_glyph_segment_lookup_unit_test.sv
// Testbench of the UTF-8 glyph segment lookup unit: directed and random byte streams.
`timescale 1ns / 100ps

module utf8_glyph_segment_lookup_unit_test;
  import utf8gl_pkg::*;

  localparam int RESET_CYCLES     = 6;
  localparam int SETTLE_CYCLES    = 4;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES    = 10;
  localparam int PHASE_ITEMS      = 100;
  localparam int SEG_LIMIT        = 4;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    kind_e                kind;
    logic [CP_W-1:0]      value;
    logic [SEG_IDX_W-1:0] seg;
    logic [CP_W-1:0]      offset;
  } glyph_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           text_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           result_kind;
  logic [CP_W-1:0]      char_value;
  logic [SEG_IDX_W-1:0] segment_index;
  logic [CP_W-1:0]      glyph_offset;

  // Shadow of the configuration registers and of the decoder state.
  logic                 cfg_utf8 = 1'b0;
  logic                 cfg_segmented = 1'b0;
  logic [COUNT_W-1:0]   cfg_count = '0;
  logic [RANGE_W-1:0]   cfg_range [SEG_LIMIT] = '{default: '0};
  logic [CP_W-1:0]      code_acc = '0;
  logic [1:0]           pending = '0;

  glyph_result_t        expected_glyphs [$];
  int                   mismatch_count = 0;
  int                   bytes_accepted = 0;
  bit                   idle_enable = 1'b0;
  bit                   long_hold_request = 1'b0;

  utf8_glyph_segment_lookup_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .text_byte_i    (text_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (result_kind),
    .char_value_o   (char_value),
    .segment_index_o(segment_index),
    .glyph_offset_o (glyph_offset)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Decodes one byte against the shadow state and tells whether it yields a glyph request.
  function automatic bit predict_glyph(input logic [7:0] b, output glyph_result_t r);
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    int unsigned     limit;
    int unsigned     i;
    r = '0;
    cp = CP_W'(b);
    if (cfg_utf8) begin
      if (b[7] == 1'b0) begin
        r.kind = KIND_ASCII;
        r.value = cp;
        return 1'b1;
      end
      if (b[7:5] == 3'b110) begin
        code_acc = CP_W'(b[4:0]);
        pending = 2'd1;
        return 1'b0;
      end
      if (b[7:4] == 4'b1110) begin
        code_acc = CP_W'(b[3:0]);
        pending = 2'd2;
        return 1'b0;
      end
      if (b[7:3] == 5'b11110) begin
        code_acc = CP_W'(b[2:0]);
        pending = 2'd3;
        return 1'b0;
      end
      if (b[7:6] == 2'b10 && pending != 2'd0) begin
        code_acc = {code_acc[CP_W-CONT_BITS-1:0], b[5:0]};
        pending = pending - 2'd1;
        if (pending != 2'd0) return 1'b0;
        cp = code_acc;
        code_acc = '0;
      end else begin
        // Stray continuation or invalid byte resets the decoder.
        code_acc = '0;
        pending = '0;
        return 1'b0;
      end
    end
    if (cfg_count == '0) begin
      r.kind = KIND_RAW;
      r.value = CP_W'(cp[7:0]);
      return 1'b1;
    end
    limit = (cfg_count > SEG_LIMIT) ? SEG_LIMIT : cfg_count;
    if (!cfg_segmented) limit = 1;
    code_acc = '0;
    for (i = 0; i < limit; i++) begin
      lo = cfg_range[i][CP_W-1:0];
      hi = cfg_range[i][RANGE_W-1:CP_W];
      if (cp >= lo && cp <= hi) begin
        r.kind = KIND_FOUND;
        r.value = cp;
        r.seg = SEG_IDX_W'(i);
        r.offset = cp - lo;
        return 1'b1;
      end
    end
    r.kind = KIND_NOTFOUND;
    r.value = cp;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_UTF8_MODE: cfg_utf8 = value[0];
      REG_SEGMENTED: cfg_segmented = value[0];
      REG_SEG_COUNT: cfg_count = value[COUNT_W-1:0];
      REG_RANGE0, REG_RANGE1, REG_RANGE2, REG_RANGE3:
        cfg_range[idx - REG_RANGE0] = value[RANGE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_text_byte(input logic [7:0] b);
    glyph_result_t res;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_accepted++;
    if (predict_glyph(b, res)) expected_glyphs.push_back(res);
  endtask

  // Shortest UTF-8 form of two or more bytes, so small code points become overlong forms.
  task automatic send_code_point(input logic [CP_W-1:0] cp);
    if (cp < 21'h800) begin
      send_text_byte({3'b110, cp[10:6]});
      send_text_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      send_text_byte({4'b1110, cp[15:12]});
      send_text_byte({2'b10, cp[11:6]});
      send_text_byte({2'b10, cp[5:0]});
    end else begin
      send_text_byte({5'b11110, cp[20:18]});
      send_text_byte({2'b10, cp[17:12]});
      send_text_byte({2'b10, cp[11:6]});
      send_text_byte({2'b10, cp[5:0]});
    end
  endtask

  // Lowers the request and waits until every expected glyph has come out, then lets the
  // pipeline settle so that bytes giving no result are out of the unit too.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_glyphs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_glyphs.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never arrived", expected_glyphs.size()));
      expected_glyphs.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    glyph_result_t got;
    glyph_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = kind_e'(result_kind);
      got.value = char_value;
      got.seg = segment_index;
      got.offset = glyph_offset;
      if (expected_glyphs.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind %0d value %h seg %0d offset %h",
                                got.kind, got.value, got.seg, got.offset));
      end else begin
        want = expected_glyphs.pop_front();
        if (got.kind !== want.kind || got.value !== want.value ||
            got.seg !== want.seg || got.offset !== want.offset) begin
          note_mismatch($sformatf(
              "expected kind %0d value %h seg %0d offset %h, got kind %0d value %h seg %0d offset %h",
              want.kind, want.value, want.seg, want.offset,
              got.kind, got.value, got.seg, got.offset));
        end
      end
    end
  end

  initial begin : result_receiver
    forever begin
      @(posedge clk);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_byte_mode();
    // Reset state: byte mode with no font loaded.
    send_text_byte(8'h00);
    send_text_byte(8'hFF);
    wait_for_results();
    reg_write(REG_SEG_COUNT, 1);
    reg_write(REG_RANGE0, {21'h7F, 21'h40});
    send_text_byte(8'h3F);
    send_text_byte(8'h40);
    send_text_byte(8'hFF);
  endtask

  task automatic test_utf8_decode();
    wait_for_results();
    reg_write(REG_UTF8_MODE, 1);
    reg_write(REG_SEG_COUNT, 0);
    send_text_byte(8'h7F);
    send_text_byte(8'hC2);
    send_text_byte(8'hA9);
    // Largest value a four-byte lead can carry.
    send_text_byte(8'hF7);
    send_text_byte(8'hBF);
    send_text_byte(8'hBF);
    send_text_byte(8'hBF);
    send_text_byte(8'h80);
    send_text_byte(8'hF8);
  endtask

  task automatic test_segment_search();
    wait_for_results();
    reg_write(REG_SEGMENTED, 1);
    reg_write(REG_SEG_COUNT, 7);
    reg_write(REG_RANGE0, {21'h0FF, 21'h100});
    reg_write(REG_RANGE1, {21'h20AF, 21'h20A0});
    reg_write(REG_RANGE2, {21'h2FFF, 21'h2000});
    reg_write(REG_RANGE3, {21'h1F64F, 21'h1F600});
    // An ASCII byte inside a sequence leaves the sequence going.
    send_text_byte(8'hE2);
    send_text_byte(8'h41);
    send_text_byte(8'h82);
    send_text_byte(8'hAC);
    send_code_point(21'h1F600);
    wait_for_results();
    reg_write(REG_SEGMENTED, 0);
    send_code_point(21'h00A9);
  endtask

  task automatic test_mode_switch();
    wait_for_results();
    reg_write(REG_SEG_COUNT, 1);
    reg_write(REG_RANGE0, {21'h1FFFFF, 21'h0});
    send_text_byte(8'hE2);
    wait_for_results();
    // Byte mode with a font clears the accumulator but keeps the pending count.
    reg_write(REG_UTF8_MODE, 0);
    send_text_byte(8'h41);
    wait_for_results();
    reg_write(REG_UTF8_MODE, 1);
    send_text_byte(8'h82);
    send_text_byte(8'hAC);
  endtask

  task automatic test_output_backpressure();
    int n;
    wait_for_results();
    idle_enable = 1'b0;
    reg_write(REG_SEGMENTED, 1);
    reg_write(REG_SEG_COUNT, 2);
    reg_write(REG_RANGE0, {21'h7FF, 21'h0});
    reg_write(REG_RANGE1, {21'h1FFFFF, 21'h800});
    long_hold_request = 1'b1;
    for (n = 0; n < 40; n++) begin
      if (n % 3 == 0) send_text_byte(8'($urandom_range(0, 8'h7F)));
      else send_code_point(CP_W'($urandom_range(0, 21'h1FFFFF)));
    end
    wait_for_results();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_stream();
    int              phase;
    int              k;
    int              phase_end;
    int unsigned     scale;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     sel;
    bit              paused;
    logic [CP_W-1:0] cp;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      idle_enable = (phase < RANDOM_PHASES - 2);
      reg_write(REG_UTF8_MODE, (phase % 4 == 2) ? 0 : 1);
      reg_write(REG_SEGMENTED, (phase == 0) ? 0 : (phase == 1) ? 1 : $urandom_range(0, 1));
      case (phase)
        0: reg_write(REG_SEG_COUNT, 0);
        1: reg_write(REG_SEG_COUNT, 7);
        2: reg_write(REG_SEG_COUNT, 4);
        3: reg_write(REG_SEG_COUNT, 1);
        default: reg_write(REG_SEG_COUNT, $urandom_range(0, 7));
      endcase
      case ($urandom_range(0, 2))
        0: scale = 21'h7FF;
        1: scale = 21'hFFFF;
        default: scale = 21'h1FFFFF;
      endcase
      if (!cfg_utf8) scale = 8'hFF;
      for (k = 0; k < SEG_LIMIT; k++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          lo = 0;
          hi = 21'h1FFFFF;
        end else if (sel == 1) begin
          lo = $urandom_range(1, scale);
          hi = $urandom_range(0, lo - 1);
        end else begin
          lo = $urandom_range(0, scale);
          hi = lo + $urandom_range(0, scale / 4);
          if (hi > 21'h1FFFFF) hi = 21'h1FFFFF;
        end
        reg_write(reg_idx_e'(REG_RANGE0 + k), {CP_W'(hi), CP_W'(lo)});
      end
      phase_end = bytes_accepted + PHASE_ITEMS;
      paused = 1'b0;
      while (bytes_accepted < phase_end) begin
        if (phase == 3 && !paused && bytes_accepted > phase_end - PHASE_ITEMS / 2) begin
          // Sender holds back until the unit has handed out everything.
          paused = 1'b1;
          wait_for_results();
        end
        sel = $urandom_range(0, 19);
        if (!cfg_utf8 || sel < 3) begin
          send_text_byte(8'($urandom_range(0, 255)));
        end else if (sel < 5) begin
          send_text_byte(8'($urandom_range(0, 8'h7F)));
        end else if (sel == 5) begin
          // Lead byte whose sequence is cut short by whatever follows.
          send_text_byte(8'($urandom_range(8'hC0, 8'hF7)));
        end else begin
          k = $urandom_range(0, SEG_LIMIT - 1);
          lo = cfg_range[k][CP_W-1:0];
          hi = cfg_range[k][RANGE_W-1:CP_W];
          if (sel < 15 && cfg_count != 0 && lo <= hi) cp = CP_W'($urandom_range(lo, hi));
          else cp = CP_W'($urandom_range(0, scale));
          send_code_point(cp);
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_enable = 1'b1;
    test_byte_mode();
    test_utf8_decode();
    test_segment_search();
    test_mode_switch();
    test_output_backpressure();
    test_random_stream();
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
